/* hdl/ble_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list engine package
// Shared sizes, payload structs, command codes and word helpers.
// ----------------------------------------------------------------------------
package ble_pkg;

   // Capacity of the list and width of one stored word.
   localparam int DEPTH       = 16;
   localparam int WORD_BITS   = 32;
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int LEN_W       = $clog2(DEPTH + 1);

   // Depth of the command queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Operation codes as they arrive on the request channel.
   localparam logic [2:0] OP_ADD_FRONT    = 3'd0;
   localparam logic [2:0] OP_ADD_BACK     = 3'd1;
   localparam logic [2:0] OP_REMOVE_FRONT = 3'd2;
   localparam logic [2:0] OP_REMOVE_VALUE = 3'd3;
   localparam logic [2:0] OP_REVERSE      = 3'd4;
   localparam logic [2:0] OP_DUMP         = 3'd5;

   // Status codes on the response channel.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [PTR_W-1:0]     ptr_type;
   typedef logic [LEN_W-1:0]     len_type;

   // Classified command kinds handed from the front to the back.
   typedef enum logic [2:0] {
      CMD_ADD_FRONT    = 3'd0,
      CMD_ADD_BACK     = 3'd1,
      CMD_REMOVE_FRONT = 3'd2,
      CMD_REMOVE_VALUE = 3'd3,
      CMD_REVERSE      = 3'd4,
      CMD_DUMP         = 3'd5,
      CMD_NOP          = 3'd6
   } cmd_kind_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic               last;
   } rsp_payload_type;

   typedef struct packed {
      cmd_kind_type kind;
      word_type     word;
   } cmd_type;

   // Step a physical pointer by one slot, wrapping around the storage.
   function automatic ptr_type step_ptr(ptr_type p, logic up);
      ptr_type r;
      if (up) begin
         r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
      end else begin
         r = (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
      end
      return r;
   endfunction

   // Keep the low word bits of a sign-extended request value.
   function automatic word_type word_from_value(logic signed [31:0] v);
      logic signed [63:0] ext;
      ext = 64'(v);
      return ext[WORD_BITS-1:0];
   endfunction

   // Sign-extend a stored word and keep 32 bits for the response.
   function automatic logic signed [31:0] element_from_word(word_type w);
      logic signed [63:0] ext;
      ext = 64'($signed(w));
      return ext[31:0];
   endfunction

endpackage

/* hdl/ble_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list engine front
// Accepts request transfers and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module ble_front
   import ble_pkg::*;
(
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            cmd_valid,
   input  logic            cmd_stall,
   output cmd_type         cmd
);

   // A request moves straight on whenever the queue has room.
   assign cmd_valid = req_valid;
   assign req_stall = cmd_stall;

   // Decode the operation; unused codes become a no-op command.
   always_comb begin
      cmd.word = word_from_value(req_payload.value);
      case (req_payload.operation)
         OP_ADD_FRONT:    cmd.kind = CMD_ADD_FRONT;
         OP_ADD_BACK:     cmd.kind = CMD_ADD_BACK;
         OP_REMOVE_FRONT: cmd.kind = CMD_REMOVE_FRONT;
         OP_REMOVE_VALUE: cmd.kind = CMD_REMOVE_VALUE;
         OP_REVERSE:      cmd.kind = CMD_REVERSE;
         OP_DUMP:         cmd.kind = CMD_DUMP;
         default:         cmd.kind = CMD_NOP;
      endcase
   end

endmodule

/* hdl/ble_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list engine command queue
// A short FIFO that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module ble_queue
   import ble_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_pop,
   output cmd_type out_cmd
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                pop;

   assign in_stall  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_pop && out_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

/* hdl/ble_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list engine back
// Executes commands on a circular word store with head, tail and direction.
// ----------------------------------------------------------------------------
module ble_back
   import ble_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   output logic            cmd_pop,
   input  cmd_type         cmd,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DUMP  = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   ptr_type         head_ff, head_in;
   ptr_type         tail_ff, tail_in;
   len_type         len_ff, len_in;
   logic            rev_ff, rev_in;
   ptr_type         p_ff, p_in;
   ptr_type         cmp_ff, cmp_in;
   logic            primed_ff, primed_in;
   word_type        val_ff, val_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // Word store: one write and one registered read per cycle.
   word_type        mem [DEPTH];
   word_type        rd_data_ff;
   ptr_type         rd_addr;
   logic            we;
   ptr_type         wa;
   word_type        wd;

   logic            out_ok;
   ptr_type         head_fwd, head_bwd, tail_fwd, tail_bwd;
   ptr_type         p_fwd, cmp_fwd;
   logic            full;
   logic            empty;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // The response register can load when empty or being drained.
   assign out_ok = !rsp_valid_ff || !rsp_stall;
   assign full   = (len_ff == LEN_W'(DEPTH));
   assign empty  = (len_ff == '0);

   // Logical neighbors: forward follows the list order, whatever its direction.
   assign head_fwd = step_ptr(head_ff, !rev_ff);
   assign head_bwd = step_ptr(head_ff, rev_ff);
   assign tail_fwd = step_ptr(tail_ff, !rev_ff);
   assign tail_bwd = step_ptr(tail_ff, rev_ff);
   assign p_fwd    = step_ptr(p_ff, !rev_ff);
   assign cmp_fwd  = step_ptr(cmp_ff, !rev_ff);

   // Command sequencer.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      len_in       = len_ff;
      rev_in       = rev_ff;
      p_in         = p_ff;
      cmp_in       = cmp_ff;
      primed_in    = primed_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      rd_addr      = p_ff;
      we           = 1'b0;
      wa           = head_ff;
      wd           = cmd.word;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_ADD_FRONT, CMD_ADD_BACK: begin
                     if (out_ok) begin
                        cmd_pop            = 1'b1;
                        rsp_valid_in       = 1'b1;
                        rsp_data_in        = '0;
                        rsp_data_in.last   = 1'b1;
                        if (full) begin
                           rsp_data_in.status = STATUS_FULL;
                        end else begin
                           rsp_data_in.status = STATUS_OK;
                           len_in             = len_ff + LEN_W'(1);
                           we                 = 1'b1;
                           if (empty) begin
                              wa      = head_ff;
                              tail_in = head_ff;
                           end else if (cmd.kind == CMD_ADD_FRONT) begin
                              wa      = head_bwd;
                              head_in = head_bwd;
                           end else begin
                              wa      = tail_fwd;
                              tail_in = tail_fwd;
                           end
                        end
                     end
                  end
                  CMD_REMOVE_FRONT: begin
                     if (out_ok) begin
                        cmd_pop          = 1'b1;
                        rsp_valid_in     = 1'b1;
                        rsp_data_in      = '0;
                        rsp_data_in.last = 1'b1;
                        if (empty) begin
                           rsp_data_in.status = STATUS_EMPTY;
                        end else begin
                           rsp_data_in.status = STATUS_OK;
                           len_in             = len_ff - LEN_W'(1);
                           if (len_ff != LEN_W'(1)) begin
                              head_in = head_fwd;
                           end
                        end
                     end
                  end
                  CMD_REVERSE: begin
                     if (out_ok) begin
                        cmd_pop          = 1'b1;
                        rsp_valid_in     = 1'b1;
                        rsp_data_in      = '0;
                        rsp_data_in.last = 1'b1;
                        if (empty) begin
                           rsp_data_in.status = STATUS_EMPTY;
                        end else begin
                           // Swapping the ends and the direction reverses in place.
                           rsp_data_in.status = STATUS_OK;
                           head_in            = tail_ff;
                           tail_in            = head_ff;
                           rev_in             = !rev_ff;
                        end
                     end
                  end
                  CMD_REMOVE_VALUE, CMD_DUMP: begin
                     if (empty) begin
                        if (out_ok) begin
                           cmd_pop            = 1'b1;
                           rsp_valid_in       = 1'b1;
                           rsp_data_in        = '0;
                           rsp_data_in.last   = 1'b1;
                           rsp_data_in.status = STATUS_EMPTY;
                        end
                     end else begin
                        cmd_pop   = 1'b1;
                        val_in    = cmd.word;
                        p_in      = head_ff;
                        primed_in = 1'b0;
                        state_in  = (cmd.kind == CMD_DUMP) ? ST_DUMP : ST_SCAN;
                     end
                  end
                  default: begin
                     if (out_ok) begin
                        cmd_pop            = 1'b1;
                        rsp_valid_in       = 1'b1;
                        rsp_data_in        = '0;
                        rsp_data_in.last   = 1'b1;
                        rsp_data_in.status = STATUS_OK;
                     end
                  end
               endcase
            end
         end

         // Walk from the front, comparing each word with the value once the registered read port returns it.
         ST_SCAN: begin
            if (primed_ff && (rd_data_ff == val_ff)) begin
               p_in      = cmp_fwd;
               primed_in = 1'b0;
               state_in  = ST_SHIFT;
            end else if (primed_ff && (cmp_ff == tail_ff)) begin
               rd_addr = cmp_ff;
               if (out_ok) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in        = '0;
                  rsp_data_in.last   = 1'b1;
                  rsp_data_in.status = STATUS_NOT_FOUND;
                  state_in           = ST_IDLE;
               end
            end else begin
               rd_addr   = p_ff;
               p_in      = p_fwd;
               cmp_in    = p_ff;
               primed_in = 1'b1;
            end
         end

         // Close the gap: each word after the match moves one place forward.
         ST_SHIFT: begin
            if (cmp_ff == tail_ff) begin
               if (out_ok) begin
                  tail_in            = tail_bwd;
                  len_in             = len_ff - LEN_W'(1);
                  rsp_valid_in       = 1'b1;
                  rsp_data_in        = '0;
                  rsp_data_in.last   = 1'b1;
                  rsp_data_in.status = STATUS_OK;
                  state_in           = ST_IDLE;
               end
            end else if (!primed_ff) begin
               rd_addr   = p_ff;
               p_in      = p_fwd;
               primed_in = 1'b1;
            end else if (cmp_fwd == tail_ff) begin
               rd_addr = cmp_fwd;
               if (out_ok) begin
                  we                 = 1'b1;
                  wa                 = cmp_ff;
                  wd                 = rd_data_ff;
                  tail_in            = tail_bwd;
                  len_in             = len_ff - LEN_W'(1);
                  rsp_valid_in       = 1'b1;
                  rsp_data_in        = '0;
                  rsp_data_in.last   = 1'b1;
                  rsp_data_in.status = STATUS_OK;
                  state_in           = ST_IDLE;
               end
            end else begin
               we      = 1'b1;
               wa      = cmp_ff;
               wd      = rd_data_ff;
               cmp_in  = cmp_fwd;
               rd_addr = p_ff;
               p_in    = p_fwd;
            end
         end

         // Stream every word in list order, one transfer per cycle while the receiver does not stall.
         ST_DUMP: begin
            if (primed_ff && out_ok) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.status  = STATUS_OK;
               rsp_data_in.element = element_from_word(rd_data_ff);
               rsp_data_in.last    = (cmp_ff == tail_ff);
               if (cmp_ff == tail_ff) begin
                  state_in = ST_IDLE;
               end
            end
            if (!primed_ff || out_ok) begin
               rd_addr   = p_ff;
               cmp_in    = p_ff;
               p_in      = p_fwd;
               primed_in = 1'b1;
            end else begin
               rd_addr = cmp_ff;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         len_ff       <= '0;
         rev_ff       <= 1'b0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         len_ff       <= len_in;
         rev_ff       <= rev_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and pointer registers that need no reset.
   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      cmp_ff      <= cmp_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Word store.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

/* hdl/bounded_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list engine
// An ordered list of up to DEPTH words with front, back and search operations.
// ----------------------------------------------------------------------------
// Usage: a request transfer carries an operation and a value; each request
// yields one response transfer with a status, except a dump of a non-empty
// list, which yields one transfer per element with last set on the final one.
// Both channels use valid and stall; a transfer happens when valid is high
// and stall is low. Requests pass through a four-entry command queue, so the
// request side keeps moving while the back end works or the response waits.
// Add, remove front, reverse and unknown codes pass through the command
// queue and are answered from the idle state through the response register.
// Remove value walks the list from the front, one word per cycle through the
// registered read port of the word store, then shifts the remaining words
// one per cycle. A dump passes through the queue and the registered read port,
// then issues one element per cycle while the receiver does not stall.
// Reset empties the list and the queue at once; no clearing pass is needed.
// When the receiver stalls, the response register holds and the back end
// waits; the queue then fills and stalls the request side.
// ----------------------------------------------------------------------------
module bounded_list_engine
   import ble_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic    front_valid;
   logic    front_stall;
   cmd_type front_cmd;
   logic    queue_valid;
   logic    queue_pop;
   cmd_type queue_cmd;

   ble_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (front_valid),
      .cmd_stall   (front_stall),
      .cmd         (front_cmd)
   );

   ble_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_pop   (queue_pop),
      .out_cmd   (queue_cmd)
   );

   ble_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (queue_valid),
      .cmd_pop     (queue_pop),
      .cmd         (queue_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list engine testbench
// A table of directed requests covers the empty, single-element and full
// list, the final-position match and the unused operation codes. Random
// requests in phases biased toward filling, draining or a mix follow. Each
// response transfer is checked field by field against the table or a shadow list.
// ----------------------------------------------------------------------------
module tb_top
   import ble_pkg::*;
();

   // Operation codes that the block ignores.
   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 280;
   localparam int PHASE_ITEMS  = 40;
   localparam int DRAIN_CYCLES = 40;
   localparam int NUM_ROWS     = 21;

   // Random phase biases.
   localparam int BIAS_FILL  = 0;
   localparam int BIAS_DRAIN = 1;
   localparam int BIAS_MIXED = 2;

   // One row of the directed table; typed rows expect a single response.
   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
      logic [4:0]         reps;
      logic               typed;
      logic [1:0]         status;
   } dir_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   // Shadow copy of the list and the responses it still owes.
   word_type        shadow_list[$];
   rsp_payload_type list_replies[$];
   rsp_payload_type step_replies[$];

   dir_row_type     dir_table [0:NUM_ROWS-1];
   int              errors = 0;
   bit              calm_req = 1'b0;
   bit              calm_rsp = 1'b0;

   bounded_list_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #HALF_PERIOD clock = ~clock;

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h, wanted %0h", what, got, want);
      errors++;
   endtask

   // Work out the responses of one request and update the shadow list.
   task automatic apply_list_op(input logic [2:0] op, input logic signed [31:0] value);
      logic signed [63:0] wide;
      word_type           w;
      word_type           t;
      rsp_payload_type    r;
      int                 n;
      bit                 found;
      wide = value;
      w = wide[WORD_BITS-1:0];
      n = shadow_list.size();
      found = 1'b0;
      step_replies.delete();
      r.status  = STATUS_OK;
      r.element = '0;
      r.last    = 1'b1;
      case (op)
         OP_ADD_FRONT, OP_ADD_BACK: begin
            if (n >= DEPTH) begin
               r.status = STATUS_FULL;
            end else if (op == OP_ADD_FRONT) begin
               shadow_list.push_front(w);
            end else begin
               shadow_list.push_back(w);
            end
            step_replies.push_back(r);
         end
         OP_REMOVE_FRONT: begin
            if (n == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               shadow_list.delete(0);
            end
            step_replies.push_back(r);
         end
         OP_REMOVE_VALUE: begin
            if (n == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               for (int i = 0; i < n && !found; i++) begin
                  if (shadow_list[i] == w) begin
                     shadow_list.delete(i);
                     found = 1'b1;
                  end
               end
               if (!found) begin
                  r.status = STATUS_NOT_FOUND;
               end
            end
            step_replies.push_back(r);
         end
         OP_REVERSE: begin
            if (n == 0) begin
               r.status = STATUS_EMPTY;
            end
            for (int i = 0; i < n / 2; i++) begin
               t = shadow_list[i];
               shadow_list[i] = shadow_list[n - 1 - i];
               shadow_list[n - 1 - i] = t;
            end
            step_replies.push_back(r);
         end
         OP_DUMP: begin
            if (n == 0) begin
               r.status = STATUS_EMPTY;
               step_replies.push_back(r);
            end
            for (int i = 0; i < n; i++) begin
               wide = $signed(shadow_list[i]);
               r.element = wide[31:0];
               r.last = (i == n - 1);
               step_replies.push_back(r);
            end
         end
         default: begin
            step_replies.push_back(r);
         end
      endcase
   endtask

   // Offer one request after an idle gap, wait for its transfer, then predict.
   task automatic send_request(input logic [2:0] op, input logic signed [31:0] value,
                               input bit typed, input logic [1:0] status);
      int              gap;
      rsp_payload_type r;
      gap = calm_req ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= {op, value};
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
      apply_list_op(op, value);
      if (typed) begin
         r.status  = status;
         r.element = '0;
         r.last    = 1'b1;
         list_replies.push_back(r);
      end else begin
         foreach (step_replies[i]) list_replies.push_back(step_replies[i]);
      end
   endtask

   // Random value: small pool for repeats, extremes, or any word.
   function automatic logic signed [31:0] pick_value();
      int k;
      k = $urandom_range(0, 99);
      if (k < 25) return $urandom_range(0, 7);
      if (k < 35) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   // Random operation, weighted by the bias of the current phase.
   function automatic logic [2:0] pick_op(input int bias);
      int k;
      k = $urandom_range(0, 99);
      if (k < 3) return ($urandom_range(0, 1) != 0) ? OP_UNUSED_HI : OP_UNUSED_LO;
      case (bias)
         BIAS_FILL: begin
            if (k < 40) return OP_ADD_BACK;
            if (k < 70) return OP_ADD_FRONT;
            if (k < 78) return OP_REMOVE_VALUE;
            if (k < 84) return OP_REMOVE_FRONT;
            if (k < 90) return OP_REVERSE;
            return OP_DUMP;
         end
         BIAS_DRAIN: begin
            if (k < 15) return OP_ADD_BACK;
            if (k < 25) return OP_ADD_FRONT;
            if (k < 55) return OP_REMOVE_VALUE;
            if (k < 80) return OP_REMOVE_FRONT;
            if (k < 88) return OP_REVERSE;
            return OP_DUMP;
         end
         default: begin
            if (k < 20) return OP_ADD_BACK;
            if (k < 37) return OP_ADD_FRONT;
            if (k < 57) return OP_REMOVE_VALUE;
            if (k < 70) return OP_REMOVE_FRONT;
            if (k < 82) return OP_REVERSE;
            return OP_DUMP;
         end
      endcase
   endfunction

   // Request side: reset, directed table, random phases, then drain.
   initial begin
      int                 bias;
      int                 sent;
      logic [2:0]         op;
      logic signed [31:0] value;

      dir_table[0]  = '{OP_DUMP,         32'sh0,         5'd1,  1'b1, STATUS_EMPTY};
      dir_table[1]  = '{OP_REMOVE_FRONT, 32'sh0,         5'd1,  1'b1, STATUS_EMPTY};
      dir_table[2]  = '{OP_REMOVE_VALUE, 32'sh0,         5'd1,  1'b1, STATUS_EMPTY};
      dir_table[3]  = '{OP_REVERSE,      32'sh0,         5'd1,  1'b1, STATUS_EMPTY};
      dir_table[4]  = '{OP_UNUSED_LO,    32'shFFFF_FFFF, 5'd1,  1'b1, STATUS_OK};
      dir_table[5]  = '{OP_UNUSED_HI,    32'sh0,         5'd1,  1'b1, STATUS_OK};
      dir_table[6]  = '{OP_ADD_BACK,     32'sh7FFF_FFFF, 5'd1,  1'b1, STATUS_OK};
      // Reversing a single element changes nothing.
      dir_table[7]  = '{OP_REVERSE,      32'sh0,         5'd1,  1'b1, STATUS_OK};
      dir_table[8]  = '{OP_DUMP,         32'sh0,         5'd1,  1'b0, STATUS_OK};
      dir_table[9]  = '{OP_ADD_FRONT,    32'sh8000_0000, 5'd1,  1'b1, STATUS_OK};
      dir_table[10] = '{OP_REMOVE_VALUE, 32'sh1234_5678, 5'd1,  1'b1, STATUS_NOT_FOUND};
      dir_table[11] = '{OP_ADD_BACK,     32'sh0,         5'd13, 1'b1, STATUS_OK};
      dir_table[12] = '{OP_ADD_FRONT,    32'shFFFF_FFFF, 5'd1,  1'b1, STATUS_OK};
      // The list is full now; both adds must bounce.
      dir_table[13] = '{OP_ADD_BACK,     32'sh55,        5'd1,  1'b1, STATUS_FULL};
      dir_table[14] = '{OP_ADD_FRONT,    32'sh0,         5'd1,  1'b1, STATUS_FULL};
      dir_table[15] = '{OP_DUMP,         32'sh0,         5'd1,  1'b0, STATUS_OK};
      dir_table[16] = '{OP_REVERSE,      32'sh0,         5'd1,  1'b1, STATUS_OK};
      // After the reverse, the all-ones word sits in the final position.
      dir_table[17] = '{OP_REMOVE_VALUE, 32'shFFFF_FFFF, 5'd1,  1'b1, STATUS_OK};
      dir_table[18] = '{OP_REMOVE_VALUE, 32'sh7FFF_FFFF, 5'd1,  1'b1, STATUS_OK};
      dir_table[19] = '{OP_REMOVE_FRONT, 32'sh0,         5'd1,  1'b1, STATUS_OK};
      dir_table[20] = '{OP_DUMP,         32'sh0,         5'd1,  1'b0, STATUS_OK};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; a repeated row steps its value by one each time.
      for (int row = 0; row < NUM_ROWS; row++) begin
         for (int rep = 0; rep < dir_table[row].reps; rep++) begin
            send_request(dir_table[row].op, dir_table[row].value + rep,
                         dir_table[row].typed, dir_table[row].status);
         end
      end

      // Random phases; ignored codes do not count toward the total.
      sent = 0;
      bias = BIAS_MIXED;
      while (sent < RANDOM_ITEMS) begin
         if (sent % PHASE_ITEMS == 0) begin
            bias = $urandom_range(BIAS_FILL, BIAS_MIXED);
            calm_req = ($urandom_range(0, 3) == 0);
            calm_rsp = ($urandom_range(0, 3) == 0);
         end
         op = pick_op(bias);
         value = pick_value();
         // Most searches look for a word that is actually held.
         if (op == OP_REMOVE_VALUE && shadow_list.size() > 0 &&
             $urandom_range(0, 9) < 7) begin
            value = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
         end
         send_request(op, value, 1'b0, STATUS_OK);
         if (op != OP_UNUSED_LO && op != OP_UNUSED_HI) begin
            sent++;
         end
      end
      req_valid <= 1'b0;

      // Wait for every owed response, then watch for strays.
      while (list_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Response side: stall for a drawn number of cycles, then take one transfer.
   initial begin
      int              hold;
      rsp_payload_type want;
      while (reset) @(posedge clock);
      forever begin
         hold = calm_rsp ? 0 : $urandom_range(0, 9);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         if (list_replies.size() == 0) begin
            report_mismatch("unexpected response", rsp_payload, '0);
         end else begin
            want = list_replies.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch("status", rsp_payload.status, want.status);
            if (rsp_payload.element !== want.element)
               report_mismatch("element", rsp_payload.element, want.element);
            if (rsp_payload.last !== want.last)
               report_mismatch("last", rsp_payload.last, want.last);
         end
      end
   end

   // Watchdog against a hung handshake.
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
